/* src/assert_macros.svh */
// Assertion helpers shared by the RTL. Every check is clocked on clk_i and
// is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* src/cku_pkg.sv */
package cku_pkg;

  // Configuration register widths and indices.
  localparam int unsigned CfgDataW  = 15;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned ScaleW    = 6;

  localparam logic [CfgIndexW-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_SCALE_FACTOR  = 2'd2;

  // Pixel payload widths.
  localparam int unsigned ChanW   = 8;
  localparam int unsigned InDataW = 4 * ChanW;
  localparam int unsigned OutDataW = 3 * ChanW;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the accepted source pixel
    logic mul;    // form the blend sums for both checker greys
    logic div;    // divide the sums by 255
    logic emit;   // load one replica into the output register
    logic last;   // this replica is the last one of the pixel
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ScaleW-1:0] scale;  // effective scale factor, 1 and above
  } status_t;

endpackage

/* src/cku_ctrl.sv */
module cku_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  cku_pkg::status_t       status_i,
  output cku_pkg::cmd_t          cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [cku_pkg::ScaleW-1:0]  rep_q, rep_d;
  logic                        out_valid_q, out_valid_d;
  logic                        emit;
  logic                        last;
  logic [cku_pkg::ScaleW-1:0]  scale_m1;

  // A replica may be loaded when the output register is empty or is being taken.
  assign scale_m1 = status_i.scale - {{(cku_pkg::ScaleW-1){1'b0}}, 1'b1};
  assign emit     = (state_q == StEmit) && (!out_valid_q || out_ready_i);
  assign last     = (rep_q == scale_m1);

  // Sequencer over capture, product, divide and replica emission.
  always_comb begin
    state_d = state_q;
    rep_d   = rep_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StMul;
        end
      end
      StMul: begin
        state_d = StDiv;
      end
      StDiv: begin
        state_d = StEmit;
        rep_d   = '0;
      end
      StEmit: begin
        if (emit) begin
          if (last) begin
            state_d = StIdle;
            rep_d   = '0;
          end else begin
            rep_d = rep_q + {{(cku_pkg::ScaleW-1){1'b0}}, 1'b1};
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // The output register stays full until the downstream side takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rep_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  assign cmd_o.load = (state_q == StIdle) && in_valid_i;
  assign cmd_o.mul  = (state_q == StMul);
  assign cmd_o.div  = (state_q == StDiv);
  assign cmd_o.emit = emit;
  assign cmd_o.last = emit && last;

endmodule

/* src/cku_datapath.sv */
module cku_datapath #(
  parameter int unsigned MAX_WIDTH = 16384,
  parameter int unsigned MAX_SCALE = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [cku_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [cku_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic [cku_pkg::InDataW-1:0]     pixel_i,
  input  cku_pkg::cmd_t                   cmd_i,
  output cku_pkg::status_t                status_o,
  output logic [cku_pkg::OutDataW-1:0]    out_data_o,
  output logic                            out_last_o
);

  localparam logic [cku_pkg::CfgDataW-1:0] MaxWidth = cku_pkg::CfgDataW'(MAX_WIDTH);
  localparam logic [cku_pkg::ScaleW-1:0]   MaxScale = cku_pkg::ScaleW'(MAX_SCALE);
  localparam logic [15:0] GreyDark  = 16'd32;
  localparam logic [15:0] GreyLight = 16'd72;
  localparam logic [15:0] RoundBias = 16'd127;

  // Exact floor(x / 255) for x up to 255 * 256 - 1, by shift and add.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  // Configuration registers.
  logic [cku_pkg::CfgDataW-1:0] width_q, height_q;
  logic [cku_pkg::ScaleW-1:0]   scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= cku_pkg::CfgDataW'(1);
      height_q <= cku_pkg::CfgDataW'(1);
      scale_q  <= cku_pkg::ScaleW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cku_pkg::CFG_SOURCE_WIDTH:  width_q  <= cfg_data_i;
        cku_pkg::CFG_SOURCE_HEIGHT: height_q <= cfg_data_i;
        cku_pkg::CFG_SCALE_FACTOR:  scale_q  <= cfg_data_i[cku_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the registers into their legal ranges.
  logic [cku_pkg::CfgDataW-1:0] w_eff, h_eff;
  logic [cku_pkg::ScaleW-1:0]   s_eff;

  assign w_eff = (width_q == '0) ? cku_pkg::CfgDataW'(1) :
                 (width_q > MaxWidth) ? MaxWidth : width_q;
  assign h_eff = (height_q == '0) ? cku_pkg::CfgDataW'(1) :
                 (height_q > MaxWidth) ? MaxWidth : height_q;
  assign s_eff = (scale_q == '0) ? cku_pkg::ScaleW'(1) :
                 (scale_q > MaxScale) ? MaxScale : scale_q;

  assign status_o.scale = s_eff;

  // Output rows per frame, refreshed every cycle from the registers.
  logic [20:0] frame_rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_rows_q <= 21'd1;
    end else begin
      frame_rows_q <= {6'd0, h_eff} * {15'd0, s_eff};
    end
  end

  // Blend pipeline: capture, sums for both greys, then divide.
  logic [2:0][7:0]  fg_q;
  logic [7:0]       alpha_q;
  logic [2:0][15:0] sum_dark_q, sum_light_q;
  logic [2:0][7:0]  mix_dark_q, mix_light_q;
  logic [7:0]       inv_alpha;

  assign inv_alpha = 8'd255 - alpha_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int c = 0; c < 3; c++) begin
        fg_q[c] <= pixel_i[8*c +: 8];
      end
      alpha_q <= pixel_i[31:24];
    end
    if (cmd_i.mul) begin
      for (int c = 0; c < 3; c++) begin
        sum_dark_q[c]  <= {8'd0, fg_q[c]} * {8'd0, alpha_q}
                          + {8'd0, inv_alpha} * GreyDark + RoundBias;
        sum_light_q[c] <= {8'd0, fg_q[c]} * {8'd0, alpha_q}
                          + {8'd0, inv_alpha} * GreyLight + RoundBias;
      end
    end
    if (cmd_i.div) begin
      for (int c = 0; c < 3; c++) begin
        mix_dark_q[c]  <= div255(sum_dark_q[c]);
        mix_light_q[c] <= div255(sum_light_q[c]);
      end
    end
  end

  // Position counters.
  logic [13:0] col_q, col_d;
  logic [4:0]  rep_q, rep_d;
  logic [19:0] ocol_q, ocol_d;
  logic [19:0] orow_q, orow_d;
  logic [14:0] col_sum;
  logic [5:0]  rep_sum;
  logic [20:0] row_sum;

  always_comb begin
    col_d   = col_q;
    rep_d   = rep_q;
    ocol_d  = ocol_q;
    orow_d  = orow_q;
    col_sum = {1'b0, col_q} + 15'd1;
    rep_sum = {1'b0, rep_q} + 6'd1;
    row_sum = {1'b0, orow_q} + 21'd1;
    if (cmd_i.emit) begin
      ocol_d = ocol_q + 20'd1;
      if (cmd_i.last) begin
        if (col_sum >= w_eff) begin
          // End of a source row: restart the row and move down one line.
          col_d  = '0;
          ocol_d = '0;
          rep_d  = (rep_sum >= s_eff) ? 5'd0 : rep_sum[4:0];
          orow_d = row_sum[19:0];
          if ((row_sum >= frame_rows_q) || row_sum[20]) begin
            orow_d = '0;
            rep_d  = '0;
          end
        end else begin
          col_d = col_sum[13:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      rep_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else begin
      col_q  <= col_d;
      rep_q  <= rep_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
    end
  end

  // Output register: pick the grey of the checker cell under this replica.
  logic light;
  logic [cku_pkg::OutDataW-1:0] out_data_q;
  logic out_last_q;

  assign light = ocol_q[3] ^ orow_q[3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      for (int c = 0; c < 3; c++) begin
        out_data_q[8*c +: 8] <= light ? mix_light_q[c] : mix_dark_q[c];
      end
      out_last_q <= cmd_i.last;
    end
  end

  assign out_data_o = out_data_q;
  assign out_last_o = out_last_q;

endmodule

/* src/checker_composite_upscale.sv */
// Channel     | Direction | Handshake                  | Payload
// s_axis      | in        | s_axis_tvalid/s_axis_tready | source RGBA pixel
// m_axis      | out       | m_axis_tvalid/m_axis_tready | blended RGB replica, tlast
// cfg         | in        | cfg_valid_i/cfg_ready_o     | register index and data
//
// Each source pixel passes through capture, product and divide, then one replica a cycle
// while the output is not stalled, counted by the controller's replica counter.
// The next pixel is taken in the cycle after its predecessor's last replica is loaded.
// A stalled output register holds the replica and pauses the replica counter.
// Reset sets every configuration register to 1 and clears all position counters.
`include "assert_macros.svh"

module checker_composite_upscale #(
  parameter int unsigned MAX_WIDTH = 16384,
  parameter int unsigned MAX_SCALE = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: src_red, src_green, src_blue, src_alpha.
  input  logic [cku_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: out_red, out_green, out_blue.
  output logic [cku_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cku_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [cku_pkg::CfgDataW-1:0]    cfg_data_i
);

  cku_pkg::cmd_t    cmd;
  cku_pkg::status_t status;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  cku_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cku_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // A request taken in must be followed by its product step, never by a replica.
  `ASSERT_HOLDS(a_accept_then_mul, (s_axis_tvalid && s_axis_tready) |=> (cmd.mul && !s_axis_tready), "accepted pixel not followed by product step")
  // A replica must not overwrite a result the downstream side has not taken.
  `ASSERT_HOLDS(a_emit_no_overwrite, cmd.emit |-> (!m_axis_tvalid || m_axis_tready), "replica loaded over a pending result")
  // The last-replica mark only comes with a replica.
  `ASSERT_HOLDS(a_last_with_emit, cmd.last |-> cmd.emit, "last mark without a replica")
  // New pixels are not taken while replicas are still being produced.
  `ASSERT_NEVER(a_ready_while_emit, s_axis_tready && cmd.emit, "input ready during replica output")

endmodule

/* tb/cku_replica_check.sv */
`timescale 1ns / 1ps

module cku_replica_check
  import cku_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 16384,
  parameter int unsigned MAX_SCALE = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pix_valid_i,
  input  logic                 pix_ready_i,
  // Fields from bit 0: src_red, src_green, src_blue, src_alpha.
  input  logic [InDataW-1:0]   pix_data_i,
  input  logic                 rep_valid_i,
  input  logic                 rep_ready_i,
  // Fields from bit 0: out_red, out_green, out_blue.
  input  logic [OutDataW-1:0]  rep_data_i,
  input  logic                 rep_last_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output int unsigned          mismatches_o,
  output int unsigned          pending_o
);

  localparam int unsigned GreyOdd   = 72;
  localparam int unsigned GreyEven  = 32;
  localparam int unsigned CellShift = 3;
  localparam int unsigned Opaque    = 255;
  localparam int unsigned Rounding  = 127;
  localparam int unsigned PosMask   = 32'h000F_FFFF;
  localparam int unsigned ColLimit  = 32'h0000_3FFF;
  localparam int unsigned RepLimit  = 32'h0000_001F;
  localparam int unsigned MaxPrints = 40;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             last;
  } replica_t;

  // Register copies and position counters of the predictor.
  logic [CfgDataW-1:0] width_reg  = '0;
  logic [CfgDataW-1:0] height_reg = '0;
  logic [ScaleW-1:0]   scale_reg  = '0;
  int unsigned         src_col    = 0;
  int unsigned         row_rep    = 0;
  int unsigned         x_pos      = 0;
  int unsigned         y_pos      = 0;
  replica_t            blended_replicas [$];

  function automatic int unsigned saturate(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [ChanW-1:0] blend(input int unsigned fg, input int unsigned bg,
                                             input int unsigned a);
    return ChanW'((fg * a + bg * (Opaque - a) + Rounding) / Opaque);
  endfunction

  // Expands one source pixel into its replicas and advances the raster position.
  task automatic composite_pixel(input logic [InDataW-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned s;
    int unsigned bg;
    replica_t    rep;
    w = saturate(width_reg, MAX_WIDTH);
    h = saturate(height_reg, MAX_WIDTH);
    s = saturate(scale_reg, MAX_SCALE);
    for (int unsigned k = 0; k < s; k++) begin
      bg = (((x_pos >> CellShift) + (y_pos >> CellShift)) & 1) ? GreyOdd : GreyEven;
      rep.red   = blend(px[0*ChanW +: ChanW], bg, px[3*ChanW +: ChanW]);
      rep.green = blend(px[1*ChanW +: ChanW], bg, px[3*ChanW +: ChanW]);
      rep.blue  = blend(px[2*ChanW +: ChanW], bg, px[3*ChanW +: ChanW]);
      rep.last  = (k + 1 == s);
      blended_replicas.push_back(rep);
      x_pos = (x_pos + 1) & PosMask;
    end
    src_col++;
    // Row end, then the wrap of the row repeat and of the whole frame.
    if (src_col >= w || src_col > ColLimit) begin
      src_col = 0;
      x_pos   = 0;
      row_rep++;
      if (row_rep >= s || row_rep > RepLimit) row_rep = 0;
      y_pos++;
      if (y_pos >= h * s || y_pos > PosMask) begin
        y_pos   = 0;
        row_rep = 0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatches_o++;
    if (mismatches_o <= MaxPrints) begin
      $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Follow every request on the three channels.
  always @(posedge clk_i or negedge rst_ni) begin
    replica_t want;
    if (!rst_ni) begin
      width_reg    = 1;
      height_reg   = 1;
      scale_reg    = 1;
      src_col      = 0;
      row_rep      = 0;
      x_pos        = 0;
      y_pos        = 0;
      blended_replicas.delete();
      pending_o    = 0;
      mismatches_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SOURCE_WIDTH:  width_reg  = cfg_data_i;
          CFG_SOURCE_HEIGHT: height_reg = cfg_data_i;
          CFG_SCALE_FACTOR:  scale_reg  = cfg_data_i[ScaleW-1:0];
          default: ;
        endcase
      end
      if (pix_valid_i && pix_ready_i) begin
        composite_pixel(pix_data_i);
      end
      if (rep_valid_i && rep_ready_i) begin
        if (blended_replicas.size() == 0) begin
          report_mismatch("replica with no pixel outstanding", 0, rep_data_i);
        end else begin
          want = blended_replicas.pop_front();
          if (rep_data_i[0*ChanW +: ChanW] !== want.red)
            report_mismatch("out_red", want.red, rep_data_i[0*ChanW +: ChanW]);
          if (rep_data_i[1*ChanW +: ChanW] !== want.green)
            report_mismatch("out_green", want.green, rep_data_i[1*ChanW +: ChanW]);
          if (rep_data_i[2*ChanW +: ChanW] !== want.blue)
            report_mismatch("out_blue", want.blue, rep_data_i[2*ChanW +: ChanW]);
          if (rep_last_i !== want.last)
            report_mismatch("run_last", want.last, rep_last_i);
        end
      end
      pending_o = blended_replicas.size();
    end
  end

endmodule

/* tb/tb_checker_composite_upscale.sv */
`timescale 1ns / 1ps

module tb_checker_composite_upscale;
  import cku_pkg::*;

  localparam logic [CfgIndexW-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned ResetCycles  = 9;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned TimeoutNs    = 1_600_000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  int unsigned          mismatches;
  int unsigned          pending;
  logic                 idle_on;
  logic                 hold_req;

  // Channel extremes and opacity corners, packed alpha/blue/green/red from the top.
  logic [InDataW-1:0] extreme_pixels [12] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'hFF00_0000,
    32'h8000_00FF, 32'h8000_FF00, 32'h01FF_0000, 32'hFE32_64C8,
    32'h7F03_0201, 32'h8080_8080, 32'h40C0_A020, 32'hC012_3456
  };

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  checker_composite_upscale dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  cku_replica_check replica_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_valid_i  (s_axis_tvalid),
    .pix_ready_i  (s_axis_tready),
    .pix_data_i   (s_axis_tdata),
    .rep_valid_i  (m_axis_tvalid),
    .rep_ready_i  (m_axis_tready),
    .rep_data_i   (m_axis_tdata),
    .rep_last_i   (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Hard ceiling on the run time.
  initial begin
    #(TimeoutNs);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Output side: short random stalls, and one long hold-off once it is asked for.
  initial begin
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        held = 1'b1;
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Offers one pixel, possibly after a short gap, and returns once it is taken.
  task automatic send_pixel(input logic [InDataW-1:0] px);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering and waits until every replica has come out.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Random colour with opacity often at either extreme.
  function automatic logic [InDataW-1:0] random_pixel();
    logic [InDataW-1:0] px;
    px = $urandom;
    case ($urandom_range(0, 3))
      0: px[3*ChanW +: ChanW] = '0;
      1: px[3*ChanW +: ChanW] = '1;
      default: ;
    endcase
    return px;
  endfunction

  initial begin
    int unsigned n;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_SOURCE_WIDTH;
    cfg_data_i    = '0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: one pixel per frame, so the frame wraps on every pixel.
    send_pixel(extreme_pixels[0]);
    send_pixel(extreme_pixels[1]);
    drain();

    // A full small frame, ending in a frame wrap.
    write_reg(CFG_SOURCE_WIDTH, 15'd3);
    write_reg(CFG_SOURCE_HEIGHT, 15'd2);
    write_reg(CFG_SCALE_FACTOR, 15'd2);
    for (int i = 0; i < 12; i++) send_pixel(extreme_pixels[i]);
    drain();

    // Out-of-range register values saturate; the spare index is ignored.
    write_reg(CFG_SOURCE_WIDTH, 15'd0);
    write_reg(CFG_SOURCE_HEIGHT, 15'h7FFF);
    write_reg(CFG_SCALE_FACTOR, 15'd63);
    write_reg(CFG_SPARE, 15'h7FFF);
    for (int i = 0; i < 3; i++) send_pixel(random_pixel());
    drain();

    // Narrow the row while part-way through it.
    write_reg(CFG_SOURCE_WIDTH, 15'd5);
    write_reg(CFG_SOURCE_HEIGHT, 15'd3);
    write_reg(CFG_SCALE_FACTOR, 15'd3);
    for (int i = 0; i < 4; i++) send_pixel(random_pixel());
    drain();
    write_reg(CFG_SOURCE_WIDTH, 15'd2);
    for (int i = 0; i < 3; i++) send_pixel(random_pixel());
    drain();

    // Random settings; the first phase runs at full scale with a long output hold-off.
    for (int p = 0; p < RandomPhases; p++) begin
      if (p == RandomPhases - 1) idle_on = 1'b0;
      if (p < 2 || $urandom_range(0, 3) != 0)
        write_reg(CFG_SOURCE_WIDTH, CfgDataW'($urandom_range(1, 4)));
      if (p < 2 || $urandom_range(0, 3) != 0)
        write_reg(CFG_SOURCE_HEIGHT, CfgDataW'($urandom_range(1, 3)));
      if (p == 0) write_reg(CFG_SCALE_FACTOR, 15'd32);
      else if (p == 1) write_reg(CFG_SCALE_FACTOR, 15'd1);
      else write_reg(CFG_SCALE_FACTOR, CfgDataW'($urandom_range(0, 4)));
      if (p == 0) hold_req = 1'b1;
      n = $urandom_range(10, 16);
      for (int i = 0; i < n; i++) send_pixel(random_pixel());
      drain();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/cku_pkg.sv
src/cku_ctrl.sv
src/cku_datapath.sv
src/checker_composite_upscale.sv
tb/cku_replica_check.sv
tb/tb_checker_composite_upscale.sv
